/* hdl/smt_pkg.sv */
package smt_pkg;

    // Fixed field widths
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned FIELD_W = 7;

    // Default table depth
    localparam int unsigned DEFAULT_CAPACITY = 64;

    // Action codes carried by a request
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEDUP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELALL = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

    // Status codes of a result
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } smt_op_t;

    // Controller state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } smt_state_t;

    // Command bus shared by all cells
    typedef struct packed {
        smt_op_t                  op;
        logic signed [DATA_W-1:0] value;
        logic                     dedup;
    } smt_cmd_t;

    // What a cell shows to its neighbours and to the controller
    typedef struct packed {
        logic signed [DATA_W-1:0] entry;
        logic                     valid;
        logic                     gt;
        logic                     eq;
        logic                     drop;
        logic                     hit;
        logic                     last;
    } smt_cell_t;

endpackage

/* hdl/smt_if.sv */
interface smt_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [smt_pkg::ACT_W-1:0]            action;
    logic signed [smt_pkg::DATA_W-1:0]    operand_value;

    modport source (output valid, output action, output operand_value, input ready);
    modport sink (input valid, input action, input operand_value, output ready);
endinterface

interface smt_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 status;
    logic [smt_pkg::FIELD_W-1:0]          insert_position;
    logic [smt_pkg::FIELD_W-1:0]          item_count;
    logic                                 is_empty;
    logic signed [smt_pkg::DATA_W-1:0]    min_value;
    logic signed [smt_pkg::DATA_W-1:0]    max_value;
    logic [smt_pkg::FIELD_W-1:0]          max_position;

    modport source (output valid, output status, output insert_position, output item_count,
                    output is_empty, output min_value, output max_value,
                    output max_position, input ready);
    modport sink (input valid, input status, input insert_position, input item_count,
                  input is_empty, input min_value, input max_value,
                  input max_position, output ready);
endinterface

/* hdl/sorted_multiset_table.sv */
// Sorted multiset table: up to CAPACITY signed 32-bit values kept in
// ascending order in a row of cells, one entry per cell.
// Request channel (req): action and operand_value. Actions are insert,
// delete duplicates keeping the first, delete all equal, and query.
// Response channel (rsp): one result per request with status, insert
// position, count, empty flag, minimum, maximum and maximum position.
// Timing: a request is taken in the idle state, worked on in the exec state,
// then reported from the report state. A delete stays in the exec state
// while an equal entry is left to drop: the cells move the tail one place
// left per cycle until no equal entry is left to drop.
// Requests are taken only while the controller is idle; one request is
// in flight at a time.
// The result sits in an output register; a new request may be taken while
// it waits, but the next result is not reported until it has been taken.
// Reset empties the table at once (all cell valid bits clear) and drops
// any pending result.
module sorted_multiset_table #(
    parameter int unsigned CAPACITY = smt_pkg::DEFAULT_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    smt_req_if.sink   req,
    smt_rsp_if.source rsp
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    smt_pkg::smt_cmd_t   cmd;
    smt_pkg::smt_cell_t  cells [CAPACITY];
    smt_pkg::smt_cell_t  edge_left;
    smt_pkg::smt_cell_t  edge_right;

    smt_pkg::smt_state_t state_reg;
    smt_pkg::smt_state_t state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                status_reg;
    logic                status_next;
    logic [smt_pkg::ACT_W-1:0]          act_reg;
    logic signed [smt_pkg::DATA_W-1:0]  value_reg;
    logic                out_valid_reg;
    logic                load_out;

    logic                               status_out_reg;
    logic [smt_pkg::FIELD_W-1:0]        pos_out_reg;
    logic [smt_pkg::FIELD_W-1:0]        count_out_reg;
    logic                               empty_out_reg;
    logic signed [smt_pkg::DATA_W-1:0]  min_out_reg;
    logic signed [smt_pkg::DATA_W-1:0]  max_out_reg;

    logic                               any_drop;
    logic [CW-1:0]                      hit_pos;
    logic signed [smt_pkg::DATA_W-1:0]  max_entry;
    logic [CW-1:0]                      report_pos;

    // Boundary cells: before the first slot everything is smaller
    always_comb
    begin
        edge_left       = '0;
        edge_left.gt    = 1'b1;
        edge_right      = '0;
    end

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        smt_pkg::smt_cell_t left_nb;
        smt_pkg::smt_cell_t right_nb;

        if (i == 0)
        begin : g_first
            assign left_nb = edge_left;
        end
        else
        begin : g_mid_l
            assign left_nb = cells[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_final
            assign right_nb = edge_right;
        end
        else
        begin : g_mid_r
            assign right_nb = cells[i+1];
        end

        smt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left       (left_nb),
            .right      (right_nb),
            .cell_state (cells[i])
        );
    end

    // Gather drop flag, inserted slot and last entry over the row
    always_comb
    begin
        any_drop  = 1'b0;
        hit_pos   = '0;
        max_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_drop = any_drop | cells[i].drop;
            if (cells[i].hit)
            begin
                hit_pos = hit_pos | CW'(i + 1);
            end
            if (cells[i].last)
            begin
                max_entry = max_entry | cells[i].entry;
            end
        end
    end

    // Controller next state and cell command
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        load_out    = 1'b0;
        req.ready   = 1'b0;
        cmd.op      = smt_pkg::OP_HOLD;
        cmd.value   = value_reg;
        cmd.dedup   = (act_reg == smt_pkg::ACT_DEDUP);
        unique case (state_reg)
            smt_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    status_next = smt_pkg::STATUS_DONE;
                    state_next  = smt_pkg::ST_EXEC;
                end
            end
            smt_pkg::ST_EXEC:
            begin
                unique case (act_reg)
                    smt_pkg::ACT_INSERT:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = smt_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            cmd.op     = smt_pkg::OP_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                        state_next = smt_pkg::ST_REPORT;
                    end
                    smt_pkg::ACT_DEDUP, smt_pkg::ACT_DELALL:
                    begin
                        if (any_drop)
                        begin
                            cmd.op     = smt_pkg::OP_SHIFT;
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            state_next = smt_pkg::ST_REPORT;
                        end
                    end
                    default:
                    begin
                        state_next = smt_pkg::ST_REPORT;
                    end
                endcase
            end
            smt_pkg::ST_REPORT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = smt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smt_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold controller state, count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smt_pkg::ST_IDLE;
            count_reg     <= '0;
            status_reg    <= smt_pkg::STATUS_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Slot reported for a successful insert, else zero
    assign report_pos = (act_reg == smt_pkg::ACT_INSERT && status_reg == smt_pkg::STATUS_DONE)
                        ? hit_pos : '0;

    // Latch the request and the result payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            act_reg   <= req.action;
            value_reg <= req.operand_value;
        end
        if (load_out)
        begin
            status_out_reg <= status_reg;
            pos_out_reg    <= smt_pkg::FIELD_W'(report_pos);
            count_out_reg  <= smt_pkg::FIELD_W'(count_reg);
            empty_out_reg  <= (count_reg == '0);
            min_out_reg    <= cells[0].valid ? cells[0].entry : '0;
            max_out_reg    <= max_entry;
        end
    end

    // Drive the response channel
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = status_out_reg;
    assign rsp.insert_position = pos_out_reg;
    assign rsp.item_count      = count_out_reg;
    assign rsp.is_empty        = empty_out_reg;
    assign rsp.min_value       = min_out_reg;
    assign rsp.max_value       = max_out_reg;
    assign rsp.max_position    = count_out_reg;

endmodule

/* hdl/smt_cell.sv */
module smt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  smt_pkg::smt_cmd_t cmd,
    input  smt_pkg::smt_cell_t left,
    input  smt_pkg::smt_cell_t right,
    output smt_pkg::smt_cell_t cell_state
);

    logic signed [smt_pkg::DATA_W-1:0] entry_reg;
    logic signed [smt_pkg::DATA_W-1:0] entry_next;
    logic                              valid_reg;
    logic                              valid_next;
    logic                              hit_reg;
    logic                              hit_next;
    logic                              gt;
    logic                              eq;
    logic                              shift;

    // Compare the broadcast operand with the held entry: gt when the operand is greater
    assign gt = valid_reg && (cmd.value > entry_reg);
    assign eq = valid_reg && (entry_reg == cmd.value);

    // Move left when this entry is dropped or lies beyond the dropped run
    always_comb
    begin
        if (cmd.dedup)
        begin
            shift = !valid_reg || !(gt || eq) || (eq && left.eq);
        end
        else
        begin
            shift = !valid_reg || !gt;
        end
    end

    // Next entry: keep, take the operand, or take a neighbour's entry
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        hit_next   = hit_reg;
        unique case (cmd.op)
            smt_pkg::OP_INSERT:
            begin
                hit_next = 1'b0;
                if (!gt)
                begin
                    if (left.gt)
                    begin
                        entry_next = cmd.value;
                        valid_next = 1'b1;
                        hit_next   = 1'b1;
                    end
                    else
                    begin
                        entry_next = left.entry;
                        valid_next = left.valid;
                    end
                end
            end
            smt_pkg::OP_SHIFT:
            begin
                if (shift)
                begin
                    entry_next = right.entry;
                    valid_next = right.valid;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold the control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Show state to neighbours and controller
    always_comb
    begin
        cell_state.entry = entry_reg;
        cell_state.valid = valid_reg;
        cell_state.gt    = gt;
        cell_state.eq    = eq;
        cell_state.drop  = cmd.dedup ? (eq && left.eq) : eq;
        cell_state.hit   = hit_reg;
        cell_state.last  = valid_reg && !right.valid;
    end

endmodule
